// ===== rtl/mwcrng_pkg.sv =====
// ----------------------------------------------------------------------------
// mwcrng_pkg
// Shared types and constants for the multiply-with-carry range generator.
// ----------------------------------------------------------------------------
package mwcrng_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam logic [WORD_W-1:0] MWC_MULT = 32'd1447497129;

    typedef enum logic
    {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } op_t;

    // one draw handed from the generator front to the range back end
    typedef struct packed
    {
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] range_min;
        logic              signed_mode;
    } draw_job_t;

    typedef enum logic [2:0]
    {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    typedef enum logic [2:0]
    {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] w);
        return {w[HALF_W-1:0], w[WORD_W-1:HALF_W]};
    endfunction

endpackage

// ===== rtl/mwcrng_front.sv =====
// ----------------------------------------------------------------------------
// mwcrng_front
// Accepts items, applies reseeds, steps the generator and queues draws.
// ----------------------------------------------------------------------------
module mwcrng_front
    import mwcrng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // seed, range_min, range_max
    input  logic [1:0]        s_tuser,   // op, signed_mode
    output logic              push_valid,
    input  logic              push_ready,
    output draw_job_t         push_job
);

    front_state_t      state_reg, state_next;
    logic [WORD_W-1:0] gen_value_reg, gen_value_next;
    logic [WORD_W-1:0] gen_carry_reg, gen_carry_next;
    logic [2*WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] span_reg, span_next;
    logic [WORD_W-1:0] min_reg, min_next;
    logic              smode_reg, smode_next;
    logic [2*WORD_W-1:0] sum;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] range_min;
    logic [WORD_W-1:0] range_max;
    op_t               op;

    assign seed      = s_tdata[31:0];
    assign range_min = s_tdata[63:32];
    assign range_max = s_tdata[95:64];
    assign op        = op_t'(s_tuser[0]);

    assign sum = prod_reg + {{WORD_W{1'b0}}, gen_carry_reg};

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_comb
    begin
        push_job.raw         = sum[WORD_W-1:0];
        push_job.span        = span_reg;
        push_job.range_min   = min_reg;
        push_job.signed_mode = smode_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        gen_value_next = gen_value_reg;
        gen_carry_next = gen_carry_reg;
        prod_next      = prod_reg;
        span_next      = span_reg;
        min_next       = min_reg;
        smode_next     = smode_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (op == OP_RESEED)
                    begin
                        gen_value_next = (seed == '0) ? WORD_W'(1) : seed;
                        gen_carry_next = swap_halves(seed) ^ seed;
                    end
                    else
                    begin
                        span_next  = range_max - range_min + WORD_W'(1);
                        min_next   = range_min;
                        smode_next = s_tuser[1];
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                prod_next  = {{WORD_W{1'b0}}, MWC_MULT} * {{WORD_W{1'b0}}, gen_value_reg};
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                // state advances only once the draw has a queue slot
                if (push_ready)
                begin
                    gen_value_next = sum[WORD_W-1:0];
                    gen_carry_next = sum[2*WORD_W-1:WORD_W];
                    state_next     = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            gen_value_reg <= WORD_W'(1);
            gen_carry_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_value_reg <= gen_value_next;
            gen_carry_reg <= gen_carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        span_reg  <= span_next;
        min_reg   <= min_next;
        smode_reg <= smode_next;
    end

endmodule

// ===== rtl/mwcrng_queue.sv =====
// ----------------------------------------------------------------------------
// mwcrng_queue
// Short first-in first-out queue of draws between front and back end.
// ----------------------------------------------------------------------------
module mwcrng_queue
    import mwcrng_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  draw_job_t                  push_job,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output draw_job_t                  pop_job,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    draw_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/mwcrng_back.sv =====
// ----------------------------------------------------------------------------
// mwcrng_back
// Reduces each draw into its range with a radix-2 remainder unit and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module mwcrng_back
    import mwcrng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  draw_job_t   pop_job,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // raw_word, ranged_value, coin_bit
);

    localparam int CNT_W = $clog2(WORD_W);

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [WORD_W-1:0] raw_reg, raw_next;
    logic [WORD_W-1:0] min_reg, min_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_raw_reg, out_raw_next;
    logic [WORD_W-1:0] out_ranged_reg, out_ranged_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] red;
    logic              out_free;
    logic              neg_a;
    logic              neg_b;

    assign pop_ready = (state_reg == B_IDLE);
    assign busy      = (state_reg != B_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_raw_reg[0], out_ranged_reg, out_raw_reg};

    assign out_free = !out_valid_reg || m_tready;
    assign neg_a    = pop_job.signed_mode && pop_job.raw[WORD_W-1];
    assign neg_b    = pop_job.signed_mode && pop_job.span[WORD_W-1];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign red   = neg_reg ? (WORD_W'(0) - rem_reg) : rem_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        div_next        = div_reg;
        raw_next        = raw_reg;
        min_next        = min_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_raw_next    = out_raw_reg;
        out_ranged_next = out_ranged_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    raw_next = pop_job.raw;
                    min_next = pop_job.range_min;
                    cnt_next = CNT_W'(WORD_W-1);
                    rem_next = '0;
                    dvd_next = neg_a ? (WORD_W'(0) - pop_job.raw) : pop_job.raw;
                    div_next = neg_b ? (WORD_W'(0) - pop_job.span) : pop_job.span;
                    neg_next = neg_a;
                    if (pop_job.span == '0)
                    begin
                        // span wrapped to zero: raw word passes unreduced
                        rem_next   = pop_job.raw;
                        neg_next   = 1'b0;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_raw_next    = raw_reg;
                    out_ranged_next = red + min_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        div_reg        <= div_next;
        raw_reg        <= raw_next;
        min_reg        <= min_next;
        neg_reg        <= neg_next;
        out_raw_reg    <= out_raw_next;
        out_ranged_reg <= out_ranged_next;
    end

endmodule

// ===== rtl/mwc_random_range_generator_core.sv =====
// path: a draw passes the multiply-add, the queue, the 32-step remainder unit and the
// output register; a zero span skips the divider
// the radix-2 remainder unit takes no new draw until the last one has left it
// reseeds are applied in the idle state, but wait while a draw holds the front for a queue slot
// reset: asynchronous, active low; value is 1, carry is 0, queue and output empty
// ----------------------------------------------------------------------------
// mwc_random_range_generator_core
// Multiply-with-carry generator with a draw reduced into a given range.
// ----------------------------------------------------------------------------
module mwc_random_range_generator_core
    import mwcrng_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // seed, range_min, range_max
    input  logic [1:0]  s_tuser,   // op, signed_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // raw_word, ranged_value, coin_bit
);

    localparam int Q_CNT_W = $clog2(QUEUE_DEPTH+1);

    logic               push_valid;
    logic               push_ready;
    draw_job_t          push_job;
    logic               pop_valid;
    logic               pop_ready;
    draw_job_t          pop_job;
    logic [Q_CNT_W-1:0] q_count;
    logic               back_busy;

    mwcrng_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    mwcrng_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .count      (q_count)
    );

    mwcrng_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .busy      (back_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a draw transaction blocks the input while the generator steps
    a_draw_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == OP_DRAW)) |=> !s_tready)
        else $error("input ready right after a draw transaction");

    // a lone push grows the queue by exactly one
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && !(pop_valid && pop_ready))
        |=> (q_count == $past(q_count) + Q_CNT_W'(1)))
        else $error("queue count did not follow a push");

    // the remainder unit takes no new draw while one is in flight
    a_back_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_busy |-> !pop_ready)
        else $error("back end popped while busy");

endmodule

// ===== bench/tb_mwc_random_range_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mwc_random_range_generator_core
// Streams reseed and draw transactions into the generator core. A scoreboard
// tracks the value and carry on its own and predicts each draw's raw word,
// coin bit and ranged value. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_mwc_random_range_generator_core
    import mwcrng_pkg::*;
();

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 500000;

    class mwc_scoreboard;
        typedef struct packed
        {
            logic [WORD_W-1:0] raw;
            logic [WORD_W-1:0] ranged;
            logic              coin;
        } draw_result_t;

        logic [WORD_W-1:0] gen_value;
        logic [WORD_W-1:0] gen_carry;
        draw_result_t      pending_draws[$];
        int unsigned       errors;
        int unsigned       draws;
        int unsigned       signed_draws;
        int unsigned       wrapped_draws;
        int unsigned       reseeds;
        int unsigned       checked;

        function new();
            gen_value = 1;
            gen_carry = 0;
        endfunction

        // signed truncating or unsigned remainder; a zero span leaves raw alone
        function logic [WORD_W-1:0] reduce(logic [WORD_W-1:0] raw,
                                           logic [WORD_W-1:0] span, logic sm);
            logic [WORD_W-1:0] mag_raw;
            logic [WORD_W-1:0] mag_span;
            logic [WORD_W-1:0] rem;
            if (span == 0)
                return raw;
            if (!sm)
                return raw % span;
            mag_raw  = raw[WORD_W-1] ? 32'd0 - raw : raw;
            mag_span = span[WORD_W-1] ? 32'd0 - span : span;
            rem      = mag_raw % mag_span;
            return raw[WORD_W-1] ? 32'd0 - rem : rem;
        endfunction

        function void note_input(op_t op, logic [WORD_W-1:0] seed, logic [WORD_W-1:0] lo,
                                 logic [WORD_W-1:0] hi, logic sm);
            logic [2*WORD_W-1:0] sum;
            logic [WORD_W-1:0]   span;
            draw_result_t        res;
            if (op == OP_RESEED)
            begin
                gen_value = (seed == 0) ? 32'd1 : seed;
                gen_carry = {seed[HALF_W-1:0], seed[WORD_W-1:HALF_W]} ^ seed;
                reseeds++;
                return;
            end
            sum = {32'd0, MWC_MULT} * {32'd0, gen_value} + {32'd0, gen_carry};
            gen_value = sum[WORD_W-1:0];
            gen_carry = sum[2*WORD_W-1:WORD_W];
            span = hi - lo + 32'd1;
            res.raw    = gen_value;
            res.coin   = gen_value[0];
            res.ranged = reduce(gen_value, span, sm) + lo;
            pending_draws.push_back(res);
            draws++;
            if (sm)
                signed_draws++;
            if (span == 0)
                wrapped_draws++;
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        endtask

        task check_result(logic [71:0] data);
            draw_result_t want;
            if (pending_draws.size() == 0)
            begin
                report("unexpected transaction", data[31:0], 32'd0);
                return;
            end
            want = pending_draws.pop_front();
            checked++;
            if (data[31:0] !== want.raw)
                report("raw_word", data[31:0], want.raw);
            if (data[63:32] !== want.ranged)
                report("ranged_value", data[63:32], want.ranged);
            if (data[64] !== want.coin)
                report("coin_bit", {31'd0, data[64]}, {31'd0, want.coin});
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // seed, range_min, range_max
    logic [1:0]  s_tuser;   // op, signed_mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // raw_word, ranged_value, coin_bit

    mwc_scoreboard sb = new();
    bit            calm;
    int unsigned   cycles;

    mwc_random_range_generator_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        calm = 1'b0;
        cycles = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d draws outstanding", cycles,
                     sb.pending_draws.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 14);

    always @(posedge clk)
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);

    task automatic send_item(op_t op, logic [31:0] seed, logic [31:0] lo,
                             logic [31:0] hi, logic sm);
        if (!calm && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo, seed};
        s_tuser  <= {sm, op};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, seed, lo, hi, sm);
    endtask

    // mix of span classes so that wrap, unit, negative and wide spans all show up
    function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        lo = $urandom;
        case (kind) inside
            0: hi = lo - 32'd1;
            1: hi = lo;
            2, 3: hi = lo + $urandom_range(1, 255);
            4: hi = lo - 32'd2;
            5: hi = lo + 32'h7FFF_FFFF;
            default: hi = $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] seed;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first draw straight from the reset state with a wrapped span
        send_item(OP_DRAW, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'd0, 32'd9, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'hFFFF_FFF6, 32'd10, 1'b1);
        // span of minus one in signed mode
        send_item(OP_DRAW, 32'd0, 32'd5, 32'd3, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_RESEED, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_DRAW, 32'hDEAD_BEEF, 32'd0, 32'd1, 1'b0);
        send_item(OP_RESEED, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_RESEED, 32'h8000_0000, 32'd7, 32'd1, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'd100, 32'd5, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'd100, 32'd5, 1'b0);
        send_item(OP_RESEED, 32'h1234_5678, 32'd0, 32'd0, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_RESEED, 32'hFFFF_0000, 32'd0, 32'd0, 1'b0);
        send_item(OP_DRAW, 32'd0, 32'd1, 32'd0, 1'b1);
        send_item(OP_DRAW, 32'd0, 32'd1, 32'd0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 700 && i < 950);
            pick_range(lo, hi);
            seed = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
            if ($urandom_range(0, 99) < 20)
                send_item(OP_RESEED, seed, lo, hi, 1'($urandom_range(0, 1)));
            else
                send_item(OP_DRAW, $urandom, lo, hi, 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.pending_draws.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d draws (%0d signed, %0d with a wrapped span) and %0d reseeds",
                 sb.draws, sb.signed_draws, sb.wrapped_draws, sb.reseeds);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
